/* rtl/mtrp_pkg.sv */
// ============================================================================
// mtrp_pkg
// Shared types and constants for the Modbus TCP request parser: function
// codes, error codes, table kinds and the result record.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package mtrp_pkg;

	// Supported function codes
	localparam logic [7:0] FC_READ_DISCRETES = 8'd2;
	localparam logic [7:0] FC_READ_HOLDING   = 8'd3;
	localparam logic [7:0] FC_READ_INPUT     = 8'd4;
	localparam logic [7:0] FC_WRITE_COIL     = 8'd5;
	localparam logic [7:0] FC_WRITE_REG      = 8'd6;
	localparam logic [7:0] FC_WRITE_MULTI    = 8'd16;

	// Frame byte positions
	localparam logic [15:0] POS_TID_HI  = 16'd0;
	localparam logic [15:0] POS_TID_LO  = 16'd1;
	localparam logic [15:0] POS_LEN_HI  = 16'd4;
	localparam logic [15:0] POS_LEN_LO  = 16'd5;
	localparam logic [15:0] POS_UNIT    = 16'd6;
	localparam logic [15:0] POS_FUNC    = 16'd7;
	localparam logic [15:0] POS_ADDR_HI = 16'd8;
	localparam logic [15:0] POS_ADDR_LO = 16'd9;
	localparam logic [15:0] POS_CNT_HI  = 16'd10;
	localparam logic [15:0] POS_CNT_LO  = 16'd11;
	localparam logic [15:0] POS_BCNT    = 16'd12;
	localparam logic [15:0] POS_DATA    = 16'd13;
	localparam logic [15:0] POS_MAX     = 16'hFFFF;

	// Error codes reported in the summary
	typedef enum logic [2:0] {
		ERR_NONE  = 3'd0,
		ERR_SHORT = 3'd1,
		ERR_LEN   = 3'd2,
		ERR_FUNC  = 3'd3,
		ERR_BCNT  = 3'd4,
		ERR_TRUNC = 3'd5
	} err_t;

	// Table kinds
	localparam logic [1:0] KIND_DISCRETES = 2'd0;
	localparam logic [1:0] KIND_COILS     = 2'd1;
	localparam logic [1:0] KIND_INPUT     = 2'd2;
	localparam logic [1:0] KIND_HOLDING   = 2'd3;

	// One result record
	typedef struct packed {
		logic        is_summary;
		logic [15:0] transaction_id;
		logic [7:0]  unit_id;
		logic [7:0]  function_code;
		logic [1:0]  table_kind;
		logic [15:0] register_address;
		logic [15:0] register_count;
		logic [15:0] data_word;
		logic [15:0] word_index;
		logic        frame_valid;
		logic [2:0]  error_code;
	} res_t;

	function automatic logic code_supported(input logic [7:0] fc);
		return (fc == FC_READ_DISCRETES) || (fc == FC_READ_HOLDING) ||
			(fc == FC_READ_INPUT) || (fc == FC_WRITE_COIL) ||
			(fc == FC_WRITE_REG) || (fc == FC_WRITE_MULTI);
	endfunction

	function automatic logic [1:0] kind_of(input logic [7:0] fc);
		logic [1:0] k;
		k = KIND_DISCRETES;
		if (fc == FC_WRITE_COIL)
			k = KIND_COILS;
		else if (fc == FC_READ_INPUT)
			k = KIND_INPUT;
		else if ((fc == FC_READ_HOLDING) || (fc == FC_WRITE_REG) || (fc == FC_WRITE_MULTI))
			k = KIND_HOLDING;
		return k;
	endfunction

endpackage

`default_nettype wire

/* rtl/modbus_tcp_request_parser_core.sv */
// ============================================================================
// modbus_tcp_request_parser_core
// Parses a Modbus TCP request frame byte by byte; emits write data words as
// they complete and an end-of-frame summary with an error code.
// ============================================================================
// Throughput: one byte beat per cycle while in_ready is high; a byte that
// ends a data word and the frame yields two results, which drain one per
// cycle while out_ready is high, in the order they were produced.
// Results pass through a four-entry register queue; input is taken while it
// has room for two. Reset clears all field state and empties the queue.
`timescale 1ns / 1ps
`default_nettype none

module modbus_tcp_request_parser_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  byte_value,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             is_summary,
	output logic [15:0]      transaction_id,
	output logic [7:0]       unit_id,
	output logic [7:0]       function_code,
	output logic [1:0]       table_kind,
	output logic [15:0]      register_address,
	output logic [15:0]      register_count,
	output logic [15:0]      data_word,
	output logic [15:0]      word_index,
	output logic             frame_valid,
	output logic [2:0]       error_code
);

	// Parser state
	logic [15:0] pos_q, tid_q, len_q, addr_q, count_q, words_q;
	logic [7:0]  unit_q, func_q, bcnt_q, pend_q;
	mtrp_pkg::err_t err_q;

	logic [15:0] nx_tid, nx_len, nx_addr, nx_count, nx_words;
	logic [7:0]  nx_unit, nx_func, nx_bcnt, nx_pend;
	mtrp_pkg::err_t nx_err, fin_err;

	logic        word_vld;
	logic [15:0] word_val, word_idx;
	logic        single, in_beat;
	logic [15:0] off;
	logic [14:0] kidx;
	logic [17:0] need;
	logic [16:0] pos_p1;

	mtrp_pkg::res_t word_res, sum_res, first_res;

	// Result queue
	mtrp_pkg::res_t fifo_q [4];
	logic [1:0] wr_ptr_q, rd_ptr_q;
	logic [2:0] cnt_q;
	logic [1:0] n_push;
	logic       pop;

	assign in_ready = (cnt_q <= 3'd2);
	assign in_beat  = in_valid && in_ready;
	assign single   = (func_q == mtrp_pkg::FC_WRITE_COIL) || (func_q == mtrp_pkg::FC_WRITE_REG);
	assign off      = pos_q - mtrp_pkg::POS_DATA;
	assign kidx     = off[15:1];

	// Field capture for the current byte
	always_comb begin
		nx_tid   = tid_q;
		nx_len   = len_q;
		nx_unit  = unit_q;
		nx_func  = func_q;
		nx_addr  = addr_q;
		nx_count = count_q;
		nx_bcnt  = bcnt_q;
		nx_pend  = pend_q;
		nx_words = words_q;
		nx_err   = err_q;
		word_vld = 1'b0;
		word_val = {pend_q, byte_value};
		word_idx = 16'd0;
		if (pos_q == mtrp_pkg::POS_TID_HI) begin
			nx_tid = {byte_value, 8'd0};
		end else if (pos_q == mtrp_pkg::POS_TID_LO) begin
			nx_tid = {tid_q[15:8], byte_value};
		end else if (pos_q == mtrp_pkg::POS_LEN_HI) begin
			nx_len = {byte_value, 8'd0};
		end else if (pos_q == mtrp_pkg::POS_LEN_LO) begin
			nx_len = {len_q[15:8], byte_value};
		end else if (pos_q == mtrp_pkg::POS_UNIT) begin
			nx_unit = byte_value;
		end else if (pos_q == mtrp_pkg::POS_FUNC) begin
			nx_func = byte_value;
			if (!mtrp_pkg::code_supported(byte_value))
				nx_err = mtrp_pkg::ERR_FUNC;
			else if ((byte_value == mtrp_pkg::FC_WRITE_COIL) ||
					(byte_value == mtrp_pkg::FC_WRITE_REG))
				nx_count = 16'd1;
		end else if ((pos_q >= mtrp_pkg::POS_ADDR_HI) && (pos_q != mtrp_pkg::POS_MAX) &&
				(err_q == mtrp_pkg::ERR_NONE)) begin
			if (pos_q == mtrp_pkg::POS_ADDR_HI) begin
				nx_addr = {byte_value, 8'd0};
			end else if (pos_q == mtrp_pkg::POS_ADDR_LO) begin
				nx_addr = {addr_q[15:8], byte_value};
			end else if (single) begin
				if (pos_q == mtrp_pkg::POS_CNT_HI) begin
					nx_pend = byte_value;
				end else if (pos_q == mtrp_pkg::POS_CNT_LO) begin
					word_vld = 1'b1;
					nx_words = 16'd1;
				end
			end else if (pos_q == mtrp_pkg::POS_CNT_HI) begin
				nx_count = {byte_value, 8'd0};
			end else if (pos_q == mtrp_pkg::POS_CNT_LO) begin
				nx_count = {count_q[15:8], byte_value};
			end else if (func_q == mtrp_pkg::FC_WRITE_MULTI) begin
				if (pos_q == mtrp_pkg::POS_BCNT) begin
					nx_bcnt = byte_value;
					if ({8'd0, byte_value} != {count_q[14:0], 1'b0} || count_q[15])
						nx_err = mtrp_pkg::ERR_BCNT;
				end else if ({1'b0, kidx} < count_q) begin
					if (!off[0]) begin
						nx_pend = byte_value;
					end else begin
						word_vld = 1'b1;
						word_idx = {1'b0, kidx};
						nx_words = {1'b0, kidx} + 16'd1;
					end
				end
			end
		end
	end

	// Summary error, by priority
	assign need   = (nx_func == mtrp_pkg::FC_WRITE_MULTI) ?
		({1'b0, nx_count, 1'b0} + 18'd13) : 18'd12;
	assign pos_p1 = {1'b0, pos_q} + 17'd1;

	always_comb begin
		if (pos_q < 16'd6)
			fin_err = mtrp_pkg::ERR_SHORT;
		else if (pos_q == mtrp_pkg::POS_MAX)
			fin_err = mtrp_pkg::ERR_LEN;
		else if ((nx_len == 16'd0) || ((pos_q - 16'd6) != (nx_len - 16'd1)))
			fin_err = mtrp_pkg::ERR_LEN;
		else if (pos_q == mtrp_pkg::POS_UNIT)
			fin_err = mtrp_pkg::ERR_TRUNC;
		else if (nx_err != mtrp_pkg::ERR_NONE)
			fin_err = nx_err;
		else if ({1'b0, pos_p1} < need)
			fin_err = mtrp_pkg::ERR_TRUNC;
		else
			fin_err = mtrp_pkg::ERR_NONE;
	end

	// Result records
	always_comb begin
		word_res.is_summary       = 1'b0;
		word_res.transaction_id   = nx_tid;
		word_res.unit_id          = nx_unit;
		word_res.function_code    = nx_func;
		word_res.table_kind       = mtrp_pkg::kind_of(nx_func);
		word_res.register_address = nx_addr;
		word_res.register_count   = nx_count;
		word_res.data_word        = word_val;
		word_res.word_index       = word_idx;
		word_res.frame_valid      = 1'b0;
		word_res.error_code       = mtrp_pkg::ERR_NONE;

		sum_res             = word_res;
		sum_res.is_summary  = 1'b1;
		sum_res.data_word   = 16'd0;
		sum_res.word_index  = nx_words;
		sum_res.frame_valid = (fin_err == mtrp_pkg::ERR_NONE);
		sum_res.error_code  = fin_err;

		first_res = word_vld ? word_res : sum_res;
	end

	assign n_push = in_beat ? ({1'b0, word_vld} + {1'b0, last_byte}) : 2'd0;
	assign pop    = out_valid && out_ready;

	// State update: everything returns to reset after the summary
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			tid_q   <= '0;
			len_q   <= '0;
			unit_q  <= '0;
			func_q  <= '0;
			addr_q  <= '0;
			count_q <= '0;
			bcnt_q  <= '0;
			pend_q  <= '0;
			words_q <= '0;
			err_q   <= mtrp_pkg::ERR_NONE;
		end else if (in_beat) begin
			if (last_byte) begin
				pos_q   <= '0;
				tid_q   <= '0;
				len_q   <= '0;
				unit_q  <= '0;
				func_q  <= '0;
				addr_q  <= '0;
				count_q <= '0;
				bcnt_q  <= '0;
				pend_q  <= '0;
				words_q <= '0;
				err_q   <= mtrp_pkg::ERR_NONE;
			end else begin
				if (pos_q != mtrp_pkg::POS_MAX)
					pos_q <= pos_q + 16'd1;
				tid_q   <= nx_tid;
				len_q   <= nx_len;
				unit_q  <= nx_unit;
				func_q  <= nx_func;
				addr_q  <= nx_addr;
				count_q <= nx_count;
				bcnt_q  <= nx_bcnt;
				pend_q  <= nx_pend;
				words_q <= nx_words;
				err_q   <= nx_err;
			end
		end
	end

	// Queue payload
	always_ff @(posedge clk) begin
		if (n_push != 2'd0)
			fifo_q[wr_ptr_q] <= first_res;
		if (n_push == 2'd2)
			fifo_q[wr_ptr_q + 2'd1] <= sum_res;
	end

	// Queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 2'd1;
			cnt_q <= cnt_q + {1'b0, n_push} - {2'b0, pop};
		end
	end

	// Output
	assign out_valid        = (cnt_q != 3'd0);
	assign is_summary       = fifo_q[rd_ptr_q].is_summary;
	assign transaction_id   = fifo_q[rd_ptr_q].transaction_id;
	assign unit_id          = fifo_q[rd_ptr_q].unit_id;
	assign function_code    = fifo_q[rd_ptr_q].function_code;
	assign table_kind       = fifo_q[rd_ptr_q].table_kind;
	assign register_address = fifo_q[rd_ptr_q].register_address;
	assign register_count   = fifo_q[rd_ptr_q].register_count;
	assign data_word        = fifo_q[rd_ptr_q].data_word;
	assign word_index       = fifo_q[rd_ptr_q].word_index;
	assign frame_valid      = fifo_q[rd_ptr_q].frame_valid;
	assign error_code       = fifo_q[rd_ptr_q].error_code;

endmodule

`default_nettype wire

/* tb/modbus_tcp_request_parser_core_tb.sv */
// ============================================================================
// modbus_tcp_request_parser_core_tb
// Drives Modbus TCP request frames into the parser one byte beat at a time and
// checks every data word and summary result against a cycle-free model of the
// frame decoder. Covers directed corner frames, long output stalls and a run
// of random well-formed and broken frames under random idling on both
// channels.
// ============================================================================
`timescale 1ns / 1ps

module modbus_tcp_request_parser_core_tb;

	import mtrp_pkg::*;

	localparam int LONG_HOLD    = 80;
	localparam int RANDOM_BEATS = 1400;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  byte_value;
	logic        last_byte;
	logic        out_valid;
	logic        out_ready;
	logic        is_summary;
	logic [15:0] transaction_id;
	logic [7:0]  unit_id;
	logic [7:0]  function_code;
	logic [1:0]  table_kind;
	logic [15:0] register_address;
	logic [15:0] register_count;
	logic [15:0] data_word;
	logic [15:0] word_index;
	logic        frame_valid;
	logic [2:0]  error_code;

	modbus_tcp_request_parser_core uut (.*);

	// Results the decoder model says are still to come, oldest first
	res_t        results_due[$];
	// Frame under construction
	logic [7:0]  frame_bytes[$];

	int          mismatches = 0;
	int          beats_sent = 0;
	bit          src_stalls = 1'b0;
	bit          sink_stalls = 1'b0;
	bit          hold_request = 1'b0;

	// Decoder model state
	logic [15:0] pos_q;
	logic [15:0] tid_q;
	logic [15:0] len_q;
	logic [15:0] addr_q;
	logic [15:0] cnt_q;
	logic [15:0] words_q;
	logic [7:0]  unit_q;
	logic [7:0]  func_q;
	logic [7:0]  hi_q;
	err_t        err_q;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Decoder model
	// ------------------------------------------------------------------------

	function automatic bit is_known_code(input logic [7:0] fc);
		case (fc)
			FC_READ_DISCRETES, FC_READ_HOLDING, FC_READ_INPUT,
			FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_MULTI: is_known_code = 1'b1;
			default: is_known_code = 1'b0;
		endcase
	endfunction

	task automatic clear_frame_state();
		pos_q   = '0;
		tid_q   = '0;
		len_q   = '0;
		addr_q  = '0;
		cnt_q   = '0;
		words_q = '0;
		unit_q  = '0;
		func_q  = '0;
		hi_q    = '0;
		err_q   = ERR_NONE;
	endtask

	function automatic res_t make_result(input logic summary, input logic [15:0] word,
		input logic [15:0] index, input err_t verdict);
		res_t r;
		r.is_summary       = summary;
		r.transaction_id   = tid_q;
		r.unit_id          = unit_q;
		r.function_code    = func_q;
		case (func_q)
			FC_WRITE_COIL: r.table_kind = KIND_COILS;
			FC_READ_INPUT: r.table_kind = KIND_INPUT;
			FC_READ_HOLDING, FC_WRITE_REG, FC_WRITE_MULTI: r.table_kind = KIND_HOLDING;
			default: r.table_kind = KIND_DISCRETES;
		endcase
		r.register_address = addr_q;
		r.register_count   = cnt_q;
		r.data_word        = word;
		r.word_index       = index;
		r.frame_valid      = summary && (verdict == ERR_NONE);
		r.error_code       = verdict;
		return r;
	endfunction

	// Append one prediction at the tail
	task automatic queue_result(input res_t r);
		results_due.insert(results_due.size(), r);
	endtask

	// Advance the model by one accepted byte beat
	task automatic decode_request_byte(input logic [7:0] b, input logic lst);
		int   off;
		int   need;
		err_t verdict;
		off = int'(pos_q) - int'(POS_DATA);
		// header, unit id and function code
		if (pos_q == POS_TID_HI) tid_q = {b, 8'h00};
		else if (pos_q == POS_TID_LO) tid_q[7:0] = b;
		else if (pos_q == POS_LEN_HI) len_q = {b, 8'h00};
		else if (pos_q == POS_LEN_LO) len_q[7:0] = b;
		else if (pos_q == POS_UNIT) unit_q = b;
		else if (pos_q == POS_FUNC) begin
			func_q = b;
			if (!is_known_code(b)) err_q = ERR_FUNC;
			else if (b == FC_WRITE_COIL || b == FC_WRITE_REG) cnt_q = 16'd1;
		end else if (pos_q >= POS_ADDR_HI && pos_q != POS_MAX && err_q == ERR_NONE) begin
			// body fields; parsing stops once an error is latched
			if (pos_q == POS_ADDR_HI) addr_q = {b, 8'h00};
			else if (pos_q == POS_ADDR_LO) addr_q[7:0] = b;
			else if (func_q == FC_WRITE_COIL || func_q == FC_WRITE_REG) begin
				if (pos_q == POS_CNT_HI) hi_q = b;
				else if (pos_q == POS_CNT_LO) begin
					queue_result(make_result(1'b0, {hi_q, b}, 16'd0, ERR_NONE));
					words_q = 16'd1;
				end
			end else if (pos_q == POS_CNT_HI) cnt_q = {b, 8'h00};
			else if (pos_q == POS_CNT_LO) cnt_q[7:0] = b;
			else if (func_q == FC_WRITE_MULTI) begin
				if (pos_q == POS_BCNT) begin
					if (int'(b) != 2 * int'(cnt_q)) err_q = ERR_BCNT;
				end else if ((off >> 1) < int'(cnt_q)) begin
					if (!off[0]) hi_q = b;
					else begin
						queue_result(make_result(1'b0, {hi_q, b}, 16'(off >> 1),
							ERR_NONE));
						words_q = 16'((off >> 1) + 1);
					end
				end
			end
		end

		// summary on the final byte, in error priority order
		if (lst) begin
			if (pos_q < POS_UNIT) verdict = ERR_SHORT;
			else if (pos_q == POS_MAX || len_q == 16'd0 ||
				int'(pos_q) - int'(POS_UNIT) != int'(len_q) - 1) verdict = ERR_LEN;
			else if (pos_q == POS_UNIT) verdict = ERR_TRUNC;
			else if (err_q != ERR_NONE) verdict = err_q;
			else begin
				need = (func_q == FC_WRITE_MULTI) ? int'(POS_DATA) + 2 * int'(cnt_q)
					: int'(POS_BCNT);
				verdict = (int'(pos_q) + 1 < need) ? ERR_TRUNC : ERR_NONE;
			end
			queue_result(make_result(1'b1, 16'd0, words_q, verdict));
			clear_frame_state();
		end else if (pos_q != POS_MAX) begin
			pos_q = pos_q + 16'd1;
		end
	endtask

	// ------------------------------------------------------------------------
	// Frame building
	// ------------------------------------------------------------------------

	function automatic int idle_length();
		return ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
	endfunction

	// Append one byte to the frame
	task automatic add_byte(input logic [7:0] b);
		frame_bytes.insert(frame_bytes.size(), b);
	endtask

	task automatic set_word(input int idx, input logic [15:0] val);
		frame_bytes[idx]     = val[15:8];
		frame_bytes[idx + 1] = val[7:0];
	endtask

	// length field counts every byte from the unit id on
	task automatic fix_length();
		if (frame_bytes.size() >= 6) set_word(POS_LEN_HI, 16'(frame_bytes.size() - 6));
	endtask

	task automatic truncate_frame(input int n);
		while (frame_bytes.size() > n) void'(frame_bytes.pop_back());
		fix_length();
	endtask

	task automatic append_noise(input int n);
		repeat (n) add_byte(8'($urandom));
	endtask

	// Well-formed request; first_word is the first data word of a write
	task automatic build_request(input logic [15:0] tid, input logic [7:0] unit,
		input logic [7:0] fc, input logic [15:0] addr, input logic [15:0] cnt,
		input logic [15:0] first_word);
		frame_bytes.delete();
		add_byte(tid[15:8]);
		add_byte(tid[7:0]);
		append_noise(2);
		add_byte(8'h00);
		add_byte(8'h00);
		add_byte(unit);
		add_byte(fc);
		add_byte(addr[15:8]);
		add_byte(addr[7:0]);
		if (fc == FC_WRITE_COIL || fc == FC_WRITE_REG) begin
			add_byte(first_word[15:8]);
			add_byte(first_word[7:0]);
		end else begin
			add_byte(cnt[15:8]);
			add_byte(cnt[7:0]);
			if (fc == FC_WRITE_MULTI) begin
				add_byte(8'(2 * int'(cnt)));
				add_byte(first_word[15:8]);
				add_byte(first_word[7:0]);
				if (cnt > 16'd1) append_noise(2 * (int'(cnt) - 1));
				if (cnt == 16'd0) truncate_frame(POS_DATA);
			end
		end
		fix_length();
	endtask

	// ------------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------------

	// One byte beat; valid stays high until the beat is taken
	task automatic send_beat(input logic [7:0] b, input logic lst);
		int gap;
		gap = (src_stalls && $urandom_range(0, 2) == 0) ? idle_length() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		byte_value <= b;
		last_byte  <= lst;
		do @(posedge clk); while (!in_ready);
		decode_request_byte(b, lst);
		beats_sent++;
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_bytes.size(); i++)
			send_beat(frame_bytes[i], i == frame_bytes.size() - 1);
	endtask

	// Stop offering beats until every predicted result is out
	task automatic wait_results_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Output side
	// ------------------------------------------------------------------------

	// Sink ready: random stalls, plus one long hold on request
	initial begin
		out_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat (idle_length()) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	function automatic string show_result(input res_t r);
		return $sformatf({"sum=%0d tid=%h unit=%h fc=%h kind=%0d addr=%h cnt=%h ",
			"word=%h idx=%0d valid=%0d err=%0d"}, r.is_summary, r.transaction_id,
			r.unit_id, r.function_code, r.table_kind, r.register_address,
			r.register_count, r.data_word, r.word_index, r.frame_valid, r.error_code);
	endfunction

	// Compare each result beat with the oldest prediction
	always @(posedge clk) begin : result_check
		res_t seen;
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			seen = {is_summary, transaction_id, unit_id, function_code, table_kind,
				register_address, register_count, data_word, word_index, frame_valid,
				error_code};
			if (results_due.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: result with none due: %s", $time, show_result(seen));
				mismatches++;
			end else begin
				want = results_due.pop_front();
				if (seen.is_summary !== want.is_summary ||
					seen.transaction_id !== want.transaction_id ||
					seen.unit_id !== want.unit_id ||
					seen.function_code !== want.function_code ||
					seen.table_kind !== want.table_kind ||
					seen.register_address !== want.register_address ||
					seen.register_count !== want.register_count ||
					seen.data_word !== want.data_word ||
					seen.word_index !== want.word_index ||
					seen.frame_valid !== want.frame_valid ||
					seen.error_code !== want.error_code) begin
					if (mismatches < 10) begin
						$display("%0t: expected %s", $time, show_result(want));
						$display("%0t: actual   %s", $time, show_result(seen));
					end
					mismatches++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	task automatic test_directed_frames();
		src_stalls  = 1'b0;
		sink_stalls = 1'b0;
		// every supported code, extreme header, address and data values
		build_request(16'h0000, 8'h00, FC_READ_DISCRETES, 16'h0000, 16'h0000, 16'h0000);
		send_frame();
		build_request(16'hFFFF, 8'hFF, FC_READ_HOLDING, 16'hFFFF, 16'hFFFF, 16'h0000);
		send_frame();
		build_request(16'h1234, 8'h01, FC_READ_INPUT, 16'h0100, 16'h000A, 16'h0000);
		send_frame();
		build_request(16'h00FF, 8'h7F, FC_WRITE_COIL, 16'h0013, 16'h0001, 16'hFF00);
		send_frame();
		build_request(16'hFF00, 8'h80, FC_WRITE_REG, 16'h8000, 16'h0001, 16'hFFFF);
		send_frame();
		build_request(16'hA5A5, 8'h5A, FC_WRITE_MULTI, 16'h0001, 16'h0003, 16'h0000);
		send_frame();
		// write of zero words
		build_request(16'h0001, 8'h02, FC_WRITE_MULTI, 16'h0002, 16'h0000, 16'h0000);
		send_frame();
		// unsupported codes
		build_request(16'h0002, 8'h03, 8'h00, 16'h0003, 16'h0001, 16'h0000);
		send_frame();
		build_request(16'h0003, 8'h04, 8'h01, 16'h0004, 16'h0001, 16'h0000);
		send_frame();
		build_request(16'h0004, 8'h05, 8'hFF, 16'h0005, 16'h0001, 16'h0000);
		send_frame();
		// byte count disagrees with the register count
		build_request(16'h0005, 8'h06, FC_WRITE_MULTI, 16'h0006, 16'h0002, 16'h1234);
		frame_bytes[POS_BCNT] = 8'd5;
		send_frame();
		// short header: one byte, then six bytes
		build_request(16'h0006, 8'h07, FC_READ_HOLDING, 16'h0007, 16'h0001, 16'h0000);
		truncate_frame(1);
		send_frame();
		build_request(16'h0007, 8'h08, FC_READ_HOLDING, 16'h0007, 16'h0001, 16'h0000);
		truncate_frame(6);
		send_frame();
		// frame ends at the unit id: function code missing
		build_request(16'h0008, 8'h09, FC_READ_HOLDING, 16'h0008, 16'h0001, 16'h0000);
		truncate_frame(7);
		send_frame();
		// length field of zero, and one off
		build_request(16'h0009, 8'h0A, FC_READ_INPUT, 16'h0009, 16'h0002, 16'h0000);
		set_word(POS_LEN_HI, 16'h0000);
		send_frame();
		build_request(16'h000A, 8'h0B, FC_READ_INPUT, 16'h000A, 16'h0002, 16'h0000);
		set_word(POS_LEN_HI, 16'(frame_bytes.size() - 5));
		send_frame();
		// truncated count, data and single write
		build_request(16'h000B, 8'h0C, FC_READ_DISCRETES, 16'h000B, 16'h0002, 16'h0000);
		truncate_frame(10);
		send_frame();
		build_request(16'h000C, 8'h0D, FC_WRITE_MULTI, 16'h000C, 16'h0002, 16'hBEEF);
		truncate_frame(15);
		send_frame();
		build_request(16'h000D, 8'h0E, FC_WRITE_REG, 16'h000D, 16'h0001, 16'hCAFE);
		truncate_frame(11);
		send_frame();
		// trailing bytes after a complete request, data beyond the count
		build_request(16'h000E, 8'h0F, FC_READ_HOLDING, 16'h000E, 16'h0004, 16'h0000);
		append_noise(3);
		fix_length();
		send_frame();
		build_request(16'h000F, 8'h10, FC_WRITE_MULTI, 16'h000F, 16'h0001, 16'h5555);
		append_noise(2);
		fix_length();
		send_frame();
		wait_results_drained();
	endtask

	// Sink holds off while write frames keep coming, so the input stalls
	task automatic test_backpressure();
		src_stalls   = 1'b0;
		sink_stalls  = 1'b0;
		hold_request = 1'b1;
		repeat (4) begin
			build_request(16'($urandom), 8'($urandom), FC_WRITE_MULTI, 16'($urandom),
				16'd4, 16'($urandom));
			send_frame();
		end
		wait_results_drained();
	endtask

	// Mostly well-formed requests with random content, some broken or noise
	task automatic test_random_frames();
		int         first;
		int         shape;
		logic [7:0] fc;
		logic [15:0] cnt;
		first = beats_sent;
		while (beats_sent - first < RANDOM_BEATS) begin
			if ($urandom_range(0, 7) == 0) src_stalls = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 7) == 0) sink_stalls = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 39) == 0) wait_results_drained();

			shape = $urandom_range(0, 19);
			case ($urandom_range(0, 5))
				0: fc = FC_READ_DISCRETES;
				1: fc = FC_READ_HOLDING;
				2: fc = FC_READ_INPUT;
				3: fc = FC_WRITE_COIL;
				4: fc = FC_WRITE_REG;
				default: fc = FC_WRITE_MULTI;
			endcase
			if (shape == 1) begin
				do fc = 8'($urandom); while (is_known_code(fc));
			end
			if (shape == 4) fc = FC_WRITE_MULTI;
			if (fc == FC_WRITE_MULTI)
				cnt = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(0, 127))
					: 16'($urandom_range(0, 6));
			else
				cnt = 16'($urandom);

			if (shape == 0) begin
				// pure noise
				frame_bytes.delete();
				append_noise($urandom_range(1, 20));
			end else begin
				build_request(16'($urandom), 8'($urandom), fc, 16'($urandom), cnt,
					16'($urandom));
				case (shape)
					2: truncate_frame($urandom_range(1, frame_bytes.size() - 1));
					3: set_word(POS_LEN_HI, ($urandom_range(0, 1) == 1)
						? 16'(frame_bytes.size() - 6 + $urandom_range(1, 3))
						: 16'(frame_bytes.size() - 6 - $urandom_range(1, 3)));
					4: frame_bytes[POS_BCNT] = frame_bytes[POS_BCNT] ^ 8'($urandom_range(1, 255));
					5: begin
						append_noise($urandom_range(1, 6));
						fix_length();
					end
					default: ;
				endcase
			end
			send_frame();
		end
		wait_results_drained();
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------

	initial begin
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		byte_value <= 8'h00;
		last_byte  <= 1'b0;
		clear_frame_state();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_frames();
		test_backpressure();
		test_random_frames();
		wait_results_drained();

		if (mismatches == 0 && results_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Run limit
	initial begin
		#40_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* modbus_tcp_request_parser_core.f */
rtl/mtrp_pkg.sv
rtl/modbus_tcp_request_parser_core.sv
tb/modbus_tcp_request_parser_core_tb.sv
